// ----- rtl/line_follow_steering_top_macros.svh -----
// Assertion macros shared by the line follow steering block.
`ifndef LINE_FOLLOW_STEERING_TOP_MACROS_SVH
`define LINE_FOLLOW_STEERING_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define LFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define LFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/lfs_pkg.sv -----
// Package with shared types and constants of the line follow steering block.
`default_nettype none
package lfs_pkg;
	typedef enum logic [1:0] {
		OP_CALIBRATE = 2'd0,
		OP_FINISH    = 2'd1,
		OP_FOLLOW    = 2'd2,
		OP_NONE      = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_BASE_SPEED     = 3'd0,
		REG_MIN_RUN_SPEED  = 3'd1,
		REG_MAX_RUN_SPEED  = 3'd2,
		REG_STEER_GAIN     = 3'd3,
		REG_STEER_REVERSE  = 3'd4,
		REG_DARK_READS_LOW = 3'd5,
		REG_LOST_THRESHOLD = 3'd6,
		REG_PWM_PERIOD     = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_SUM,
		ST_POS,
		ST_CORR,
		ST_CORR_DIV,
		ST_SPEED,
		ST_MUL,
		ST_PWM_DIV,
		ST_OUT
	} state_t;

	localparam int unsigned SCALE    = 1000;
	localparam int unsigned MIN_SPAN = 80;
	localparam int unsigned SIG_BITS = 10;

	typedef struct packed {
		logic start;
		logic dark_reads_low;
	} lane_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lane_sts_t;
endpackage
`default_nettype wire

// ----- rtl/lfs_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module lfs_divider #(
	parameter int NUM_BITS = 32,
	parameter int DEN_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [NUM_BITS-1:0] numer,
	input  wire logic [DEN_BITS-1:0] denom,
	output logic                     done,
	output logic [NUM_BITS-1:0]      quot
);
	localparam int CNT_BITS = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0] num_q;
	logic [DEN_BITS-1:0] den_q;
	logic [DEN_BITS:0]   rem_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic [DEN_BITS:0]   trial;
	logic [DEN_BITS+1:0] diff;

	// Shift in the next numerator bit and try a subtraction.
	always_comb begin
		trial = {rem_q[DEN_BITS-1:0], num_q[NUM_BITS-1]};
		diff  = {1'b0, trial} - {2'b00, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
			quot  <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_BITS-2:0], 1'b0};
			if (!diff[DEN_BITS+1]) begin
				rem_q <= diff[DEN_BITS:0];
				quot  <= {quot[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quot  <= {quot[NUM_BITS-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/lfs_lane.sv -----
// One sensor lane: keeps the bounds of its sensor and scales a sample to a signal.
`default_nettype none
module lfs_lane #(
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cal_en,
	input  wire logic                   fin_en,
	input  wire lfs_pkg::lane_ctl_t     ctl,
	input  wire logic [SAMPLE_BITS-1:0] reading,
	output lfs_pkg::lane_sts_t          sts,
	output logic [lfs_pkg::SIG_BITS-1:0] signal
);
	localparam logic [SAMPLE_BITS-1:0] SMAX = '1;
	localparam int PROD_BITS = SAMPLE_BITS + 10;

	logic [SAMPLE_BITS-1:0] lo_q, hi_q;
	logic [SAMPLE_BITS-1:0] clamped, span, diff;
	logic [SAMPLE_BITS:0]   fin_hi;
	logic [PROD_BITS-1:0]   numer, quot;
	logic                   inverted, done;
	logic                   zero_q;

	// Bounds update on calibrate and finish beats.
	always_comb begin
		fin_hi = {1'b0, lo_q} + (SAMPLE_BITS+1)'(lfs_pkg::MIN_SPAN);
		if (fin_hi > {1'b0, SMAX}) fin_hi = {1'b0, SMAX};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= SMAX;
			hi_q <= '0;
		end else if (cal_en) begin
			if (reading < lo_q) lo_q <= reading;
			if (reading > hi_q) hi_q <= reading;
		end else if (fin_en) begin
			if (hi_q < lo_q || (hi_q - lo_q) < SAMPLE_BITS'(lfs_pkg::MIN_SPAN))
				hi_q <= fin_hi[SAMPLE_BITS-1:0];
		end
	end

	// Clamp and form numerator of the scaled signal.
	always_comb begin
		inverted = lo_q > hi_q;
		clamped  = reading;
		if (clamped < lo_q) clamped = lo_q;
		if (clamped > hi_q) clamped = hi_q;
		span = hi_q - lo_q;
		if (span == '0) span = SAMPLE_BITS'(1);
		diff  = ctl.dark_reads_low ? (hi_q - clamped) : (clamped - lo_q);
		numer = PROD_BITS'(diff) * PROD_BITS'(lfs_pkg::SCALE);
	end

	always_ff @(posedge clk) begin
		if (ctl.start) zero_q <= inverted;
	end

	lfs_divider #(.NUM_BITS(PROD_BITS), .DEN_BITS(SAMPLE_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.start),
		.numer  (numer),
		.denom  (span),
		.done   (done),
		.quot   (quot)
	);

	always_comb begin
		sts.done = done;
		sts.busy = 1'b0;
		signal   = zero_q ? '0 : quot[lfs_pkg::SIG_BITS-1:0];
	end
endmodule
`default_nettype wire

// ----- rtl/line_follow_steering_top.sv -----
// Top level of the line follow steering block: lanes, merge and motor stage.
//
// Usage: input beats carry operation and one sample per sensor on in_valid and
// in_stall; one result beat per input leaves on out_valid and out_stall.
// Configuration writes use cfg_valid, cfg_ready, cfg_index and cfg_data; they
// are always ready and meant for times when the block is idle.
// Calibrate and finish beats update the bounds at the beat; these and ignored
// beats show an all-zero result in the next cycle. A follow beat passes
// through the per-lane dividers, which give the scaled signals, then the sums,
// the shared centroid divider, and then the correction, the speed clamp and
// the two PWM compare values. A lost line ends after the sums. One item is in
// the block at a time; the next input beat is taken once the result beat has
// left. Reset puts the bounds to the empty range and the registers to their
// defaults. A stalled result holds in the output register and blocks input.
//
`default_nettype none
`include "line_follow_steering_top_macros.svh"
module line_follow_steering_top #(
	parameter int SENSOR_COUNT = 8,
	parameter int SAMPLE_BITS  = 12
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [2:0]                           cfg_index,
	input  wire logic [15:0]                          cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [1:0]                           operation,
	input  wire logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] reading,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      line_found,
	output logic signed [12:0]                        position,
	output logic [1:0]                                left_direction,
	output logic [16:0]                               left_compare,
	output logic [1:0]                                right_direction,
	output logic [16:0]                               right_compare
);
	localparam int SB = lfs_pkg::SIG_BITS;
	localparam int SSUM_BITS = SB + $clog2(SENSOR_COUNT) + 1;
	localparam int WS_BITS = SSUM_BITS + 16;
	localparam int DN = 34;
	// Reciprocals for the divisions by 1000 and by 100, exact over the operand ranges.
	localparam logic [19:0] CORR_RECIP = 20'd536871;
	localparam int          CORR_SHIFT = 29;
	localparam logic [23:0] PWM_RECIP  = 24'd10737419;
	localparam int          PWM_SHIFT  = 30;

	// Configuration registers.
	logic [6:0]  base_q, minrun_q, maxrun_q, gain_q;
	logic        rev_q, dark_q;
	logic [12:0] lost_q;
	logic [15:0] period_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 7'd55; minrun_q <= 7'd30; maxrun_q <= 7'd85; gain_q <= 7'd10;
			rev_q <= 1'b0; dark_q <= 1'b1; lost_q <= 13'd220; period_q <= 16'd999;
		end else if (cfg_valid) begin
			case (lfs_pkg::reg_idx_t'(cfg_index))
				lfs_pkg::REG_BASE_SPEED:     base_q   <= cfg_data[6:0];
				lfs_pkg::REG_MIN_RUN_SPEED:  minrun_q <= cfg_data[6:0];
				lfs_pkg::REG_MAX_RUN_SPEED:  maxrun_q <= cfg_data[6:0];
				lfs_pkg::REG_STEER_GAIN:     gain_q   <= cfg_data[6:0];
				lfs_pkg::REG_STEER_REVERSE:  rev_q    <= cfg_data[0];
				lfs_pkg::REG_DARK_READS_LOW: dark_q   <= cfg_data[0];
				lfs_pkg::REG_LOST_THRESHOLD: lost_q   <= cfg_data[12:0];
				lfs_pkg::REG_PWM_PERIOD:     period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lfs_pkg::state_t state_q, state_d;
	logic in_acc, out_acc;
	logic start_q;
	lfs_pkg::op_t op;
	logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] rd_q;
	lfs_pkg::lane_ctl_t lane_ctl;
	lfs_pkg::lane_sts_t [SENSOR_COUNT-1:0] lane_sts;
	logic [SENSOR_COUNT-1:0][SB-1:0] sig;

	assign op = lfs_pkg::op_t'(operation);
	assign in_stall = (state_q != lfs_pkg::ST_IDLE) || out_valid || start_q;
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Samples held for the lanes while the division runs.
	always_ff @(posedge clk) begin
		if (in_acc) rd_q <= reading;
	end

	// The lanes start in the cycle after a follow beat, on the held samples.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_q <= 1'b0;
		else start_q <= in_acc && op == lfs_pkg::OP_FOLLOW;
	end

	assign lane_ctl.start = start_q;
	assign lane_ctl.dark_reads_low = dark_q;

	genvar g;
	generate
		for (g = 0; g < SENSOR_COUNT; g++) begin : g_lane
			lfs_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.cal_en  (in_acc && op == lfs_pkg::OP_CALIBRATE),
				.fin_en  (in_acc && op == lfs_pkg::OP_FINISH),
				.ctl     (lane_ctl),
				.reading (start_q ? rd_q[g] : reading[g]),
				.sts     (lane_sts[g]),
				.signal  (sig[g])
			);
		end
	endgenerate

	// Merge stage: signal sum and weighted sum, weights relative to the centre.
	logic [SSUM_BITS-1:0] ssum_d, ssum_q;
	logic signed [WS_BITS-1:0] wsum_d, wsum_q;
	always_comb begin
		ssum_d = '0;
		wsum_d = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			ssum_d = ssum_d + SSUM_BITS'(sig[i]);
			wsum_d = wsum_d + WS_BITS'(signed'({1'b0, sig[i]})) *
				WS_BITS'(signed'(32'(1000 * i) - 32'(500 * (SENSOR_COUNT - 1))));
		end
	end

	// Shared divider for the centroid.
	logic           dv_start, dv_done;
	logic [DN-1:0]  dv_num, dv_quot;
	logic [DN-1:0]  num_q;
	lfs_divider #(.NUM_BITS(DN), .DEN_BITS(SSUM_BITS)) u_div (
		.clk (clk), .arst_n (arst_n), .start (dv_start),
		.numer (dv_num), .denom (ssum_q), .done (dv_done), .quot (dv_quot)
	);
	assign dv_num = DN'(wsum_q < 0 ? -wsum_q : wsum_q);

	logic lost_d;
	assign lost_d = ssum_q == '0 || ssum_q < SSUM_BITS'(lost_q);

	logic        wneg_q, cneg_q, side_q, lost_q2;
	logic signed [12:0] pos_q;
	logic signed [10:0] corr_q;
	logic signed [8:0]  lsp_q, rsp_q;
	logic [16:0] lcmp_q, rcmp_q;

	// Run speed clamp.
	function automatic logic signed [8:0] run_clamp(input logic signed [11:0] s,
		input logic [6:0] mx, input logic [6:0] mn);
		logic signed [11:0] r;
		begin
			r = s;
			if (r > signed'({5'b00000, mx})) r = signed'({5'b00000, mx});
			if (r < -signed'({5'b00000, mx})) r = -signed'({5'b00000, mx});
			if (r > 0 && r < signed'({5'b00000, mn})) r = signed'({5'b00000, mn});
			run_clamp = r[8:0];
		end
	endfunction

	logic signed [12:0] pos_sat;
	logic signed [19:0] gp;
	logic signed [11:0] lsum, rsum;
	logic [6:0] lmag;
	logic [39:0] corr_prod;
	logic [10:0] corr_quo;
	logic [46:0] pwm_prod;
	logic [16:0] pwm_quo;
	always_comb begin
		pos_sat = (dv_quot > DN'(4096)) ? 13'sd4095 : 13'(dv_quot);
		if (wneg_q) pos_sat = (dv_quot > DN'(4096)) ? -13'sd4096 : -13'(dv_quot);
		if (!wneg_q && dv_quot > DN'(4095)) pos_sat = 13'sd4095;
		gp = 20'(signed'({1'b0, gain_q})) * 20'(pos_q);
		corr_prod = 40'(num_q[19:0]) * 40'(CORR_RECIP);
		corr_quo  = corr_prod[CORR_SHIFT +: 11];
		pwm_prod  = 47'(num_q[22:0]) * 47'(PWM_RECIP);
		pwm_quo   = pwm_prod[PWM_SHIFT +: 17];
		lsum = 12'(signed'({1'b0, base_q})) + 12'(corr_q);
		rsum = 12'(signed'({1'b0, base_q})) - 12'(corr_q);
		lmag = (side_q ? rsp_q : lsp_q) < 0 ? 7'(-(side_q ? rsp_q : lsp_q))
			: 7'(side_q ? rsp_q : lsp_q);
		if (lmag > 7'd100) lmag = 7'd100;
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			lfs_pkg::ST_IDLE: if (start_q) state_d = lfs_pkg::ST_DIV;
			lfs_pkg::ST_DIV:  if (lane_sts[0].done) state_d = lfs_pkg::ST_SUM;
			lfs_pkg::ST_SUM:  state_d = lost_d ? lfs_pkg::ST_OUT : lfs_pkg::ST_POS;
			lfs_pkg::ST_POS:  if (dv_done) state_d = lfs_pkg::ST_CORR;
			lfs_pkg::ST_CORR: state_d = lfs_pkg::ST_CORR_DIV;
			lfs_pkg::ST_CORR_DIV: state_d = lfs_pkg::ST_SPEED;
			lfs_pkg::ST_SPEED: state_d = lfs_pkg::ST_MUL;
			lfs_pkg::ST_MUL:  state_d = lfs_pkg::ST_PWM_DIV;
			lfs_pkg::ST_PWM_DIV: state_d = side_q ? lfs_pkg::ST_OUT : lfs_pkg::ST_MUL;
			lfs_pkg::ST_OUT:  state_d = lfs_pkg::ST_IDLE;
			default: state_d = lfs_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		dv_start = 1'b0;
		case (state_q)
			lfs_pkg::ST_SUM:  dv_start = !lost_d;
			default: dv_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lfs_pkg::ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lfs_pkg::ST_OUT || (in_acc && op != lfs_pkg::OP_FOLLOW))
				out_valid <= 1'b1;
			else if (out_acc)
				out_valid <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			line_found <= 1'b0; position <= '0;
			left_direction <= '0; left_compare <= '0;
			right_direction <= '0; right_compare <= '0;
		end
		case (state_q)
			lfs_pkg::ST_DIV: begin
				ssum_q <= ssum_d;
				wsum_q <= wsum_d;
			end
			lfs_pkg::ST_SUM: begin
				wneg_q <= wsum_q < 0;
				lost_q2 <= lost_d;
			end
			lfs_pkg::ST_POS: if (dv_done) pos_q <= pos_sat;
			lfs_pkg::ST_CORR: begin
				cneg_q <= gp < 0;
				num_q  <= DN'(gp < 0 ? -gp : gp);
			end
			lfs_pkg::ST_CORR_DIV:
				corr_q <= (cneg_q ^ rev_q) ? -11'(corr_quo) : 11'(corr_quo);
			lfs_pkg::ST_SPEED: begin
				lsp_q  <= run_clamp(lsum, maxrun_q, minrun_q);
				rsp_q  <= run_clamp(rsum, maxrun_q, minrun_q);
				side_q <= 1'b0;
			end
			lfs_pkg::ST_MUL: begin
				num_q <= DN'(24'(lmag) * (24'(period_q) + 24'd1));
			end
			lfs_pkg::ST_PWM_DIV: begin
				if (!side_q) lcmp_q <= pwm_quo;
				else rcmp_q <= pwm_quo;
				side_q <= 1'b1;
			end
			lfs_pkg::ST_OUT: if (!lost_q2) begin
				line_found <= 1'b1;
				position   <= pos_q;
				left_direction  <= lsp_q == 0 ? 2'd0 : (lsp_q > 0 ? 2'd1 : 2'd2);
				left_compare    <= lsp_q == 0 ? 17'd0 : lcmp_q;
				right_direction <= rsp_q == 0 ? 2'd0 : (rsp_q > 0 ? 2'd1 : 2'd2);
				right_compare   <= rsp_q == 0 ? 17'd0 : rcmp_q;
			end
			default: ;
		endcase
	end

	`LFS_ASSERT_IMP(a_no_input_busy, clk, arst_n, state_q != lfs_pkg::ST_IDLE, in_stall,
		"input taken while busy")
	`LFS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid,
		"result dropped under stall")
	`LFS_ASSERT_IMP(a_lost_zero, clk, arst_n, out_valid && !line_found, position == '0,
		"lost result with nonzero position")
endmodule
`default_nettype wire

// ----- tb/sv/line_follow_steering_top_tb.sv -----
// Self-checking testbench for the line follow steering block.
`timescale 1ns / 100ps
`default_nettype none
module line_follow_steering_top_tb;
	import lfs_pkg::*;

	localparam int SENSORS     = 8;
	localparam int IDLE_LIMIT  = 4000;
	localparam int SETTLE      = 120;

	// One result beat as the block presents it.
	typedef struct {
		logic              found;
		logic signed [12:0] pos;
		logic [1:0]        ldir;
		logic [16:0]       lcmp;
		logic [1:0]        rdir;
		logic [16:0]       rcmp;
	} steer_res_t;

	// Steering predictor with its own bounds, registers and pending results.
	class steer_scoreboard;
		int unsigned lo_bound[SENSORS];
		int unsigned hi_bound[SENSORS];
		int unsigned base_pct, min_pct, max_pct, gain, reverse, dark_low, lost_thr, period;
		steer_res_t  pending[$];
		int          errors;

		function void clear();
			for (int i = 0; i < SENSORS; i++) begin
				lo_bound[i] = 4095;
				hi_bound[i] = 0;
			end
			base_pct = 55; min_pct = 30; max_pct = 85; gain = 10;
			reverse = 0; dark_low = 1; lost_thr = 220; period = 999;
			pending.delete();
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [15:0] val);
			case (idx)
				REG_BASE_SPEED:     base_pct = val[6:0];
				REG_MIN_RUN_SPEED:  min_pct = val[6:0];
				REG_MAX_RUN_SPEED:  max_pct = val[6:0];
				REG_STEER_GAIN:     gain = val[6:0];
				REG_STEER_REVERSE:  reverse = val[0];
				REG_DARK_READS_LOW: dark_low = val[0];
				REG_LOST_THRESHOLD: lost_thr = val[12:0];
				REG_PWM_PERIOD:     period = val;
				default: ;
			endcase
		endfunction

		function int clamp_speed(int s);
			int mx;
			mx = max_pct;
			if (s > mx) s = mx;
			if (s < -mx) s = -mx;
			if (s > 0 && s < int'(min_pct)) s = min_pct;
			return s;
		endfunction

		function void motor(int pct, output logic [1:0] dir, output logic [16:0] cmp);
			longint mag;
			dir = 0;
			cmp = 0;
			if (pct != 0) begin
				dir = (pct > 0) ? 2'd1 : 2'd2;
				mag = (pct > 0) ? pct : -pct;
				if (mag > 100) mag = 100;
				cmp = 17'(mag * (longint'(period) + 1) / 100);
			end
		endfunction

		// Work out the result of one accepted input beat and queue it.
		function void note_input(logic [1:0] op, logic [11:0] rd[SENSORS]);
			steer_res_t  r;
			longint      wsum, p;
			int unsigned ssum, raw, span, sig;
			int          posv, corr;
			r = '{1'b0, 13'sd0, 2'd0, 17'd0, 2'd0, 17'd0};
			if (op == OP_CALIBRATE) begin
				for (int i = 0; i < SENSORS; i++) begin
					if (rd[i] < lo_bound[i]) lo_bound[i] = rd[i];
					if (rd[i] > hi_bound[i]) hi_bound[i] = rd[i];
				end
			end else if (op == OP_FINISH) begin
				for (int i = 0; i < SENSORS; i++)
					if (hi_bound[i] < lo_bound[i] || hi_bound[i] - lo_bound[i] < 80)
						hi_bound[i] = (lo_bound[i] + 80 > 4095) ? 4095 : lo_bound[i] + 80;
			end else if (op == OP_FOLLOW) begin
				wsum = 0;
				ssum = 0;
				for (int i = 0; i < SENSORS; i++) begin
					// A sensor whose bounds are still inverted gives no signal.
					if (lo_bound[i] <= hi_bound[i]) begin
						raw = rd[i];
						if (raw < lo_bound[i]) raw = lo_bound[i];
						if (raw > hi_bound[i]) raw = hi_bound[i];
						span = hi_bound[i] - lo_bound[i];
						if (span < 1) span = 1;
						sig = dark_low ? (hi_bound[i] - raw) * 1000 / span
							: (raw - lo_bound[i]) * 1000 / span;
						wsum += longint'(1000 * i - 3500) * longint'(sig);
						ssum += sig;
					end
				end
				if (ssum != 0 && ssum >= lost_thr) begin
					p = wsum / longint'(ssum);
					if (p > 4095) p = 4095;
					if (p < -4096) p = -4096;
					posv = int'(p);
					corr = (int'(gain) * posv) / 1000;
					if (reverse) corr = -corr;
					r.found = 1'b1;
					r.pos = 13'(posv);
					motor(clamp_speed(int'(base_pct) + corr), r.ldir, r.lcmp);
					motor(clamp_speed(int'(base_pct) - corr), r.rdir, r.rcmp);
				end
			end
			pending.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		// Compare one accepted result beat with the oldest expectation.
		task check_result(steer_res_t got);
			steer_res_t exp_r;
			if (pending.size() == 0) begin
				report("result beat with nothing expected");
			end else begin
				exp_r = pending.pop_front();
				if (got.found !== exp_r.found)
					report($sformatf("line_found %0b want %0b", got.found, exp_r.found));
				if (got.pos !== exp_r.pos)
					report($sformatf("position %0d want %0d", got.pos, exp_r.pos));
				if (got.ldir !== exp_r.ldir)
					report($sformatf("left_direction %0d want %0d", got.ldir, exp_r.ldir));
				if (got.lcmp !== exp_r.lcmp)
					report($sformatf("left_compare %0d want %0d", got.lcmp, exp_r.lcmp));
				if (got.rdir !== exp_r.rdir)
					report($sformatf("right_direction %0d want %0d", got.rdir, exp_r.rdir));
				if (got.rcmp !== exp_r.rcmp)
					report($sformatf("right_compare %0d want %0d", got.rcmp, exp_r.rcmp));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] operation = '0;
	logic [SENSORS-1:0][11:0] reading = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic line_found;
	logic signed [12:0] position;
	logic [1:0] left_direction, right_direction;
	logic [16:0] left_compare, right_compare;

	steer_scoreboard steer_sb = new();
	bit   gaps_on = 1'b1;
	int   stall_left = 0;
	int   idle_cycles = 0;

	line_follow_steering_top dut (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .operation, .reading, .out_valid, .out_stall,
		.line_found, .position, .left_direction, .left_compare,
		.right_direction, .right_compare
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Short gaps most of the time, an occasional long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver stall pattern.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (gaps_on) begin
			stall_left <= pick_gap();
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Accepted beats feed the predictor and the result check.
	always @(posedge clk) begin
		logic [11:0] rd[SENSORS];
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				for (int i = 0; i < SENSORS; i++)
					rd[i] = reading[i];
				steer_sb.note_input(operation, rd);
			end
			if (out_valid && !out_stall)
				steer_sb.check_result('{line_found, position, left_direction, left_compare,
					right_direction, right_compare});
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Drive one input beat and hold it until accepted, then idle for a random gap when gaps are on.
	task automatic send_item(op_t op, logic [SENSORS-1:0][11:0] rd);
		int gap;
		in_valid <= 1'b1;
		operation <= op;
		reading <= rd;
		do @(posedge clk); while (in_stall);
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold input off until every expected result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (steer_sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(reg_idx_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		steer_sb.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(int b, int mn, int mx, int g, int rv, int dk, int th, int pr);
		write_cfg(REG_BASE_SPEED, b);
		write_cfg(REG_MIN_RUN_SPEED, mn);
		write_cfg(REG_MAX_RUN_SPEED, mx);
		write_cfg(REG_STEER_GAIN, g);
		write_cfg(REG_STEER_REVERSE, rv);
		write_cfg(REG_DARK_READS_LOW, dk);
		write_cfg(REG_LOST_THRESHOLD, th);
		write_cfg(REG_PWM_PERIOD, pr);
	endtask

	// Readings with a dark or bright line near one sensor over a background.
	function automatic logic [SENSORS-1:0][11:0] line_scene();
		logic [SENSORS-1:0][11:0] rd;
		int at, bg, ln;
		at = $urandom_range(0, SENSORS - 1);
		bg = $urandom_range(0, 4095);
		ln = $urandom_range(0, 1) ? $urandom_range(0, 600) : $urandom_range(3500, 4095);
		for (int i = 0; i < SENSORS; i++) begin
			if (i == at || (i == at + 1 && $urandom_range(0, 1)))
				rd[i] = ln;
			else if ($urandom_range(0, 3) == 0)
				rd[i] = $urandom_range(0, 4095);
			else
				rd[i] = bg;
		end
		return rd;
	endfunction

	function automatic logic [SENSORS-1:0][11:0] fill(int v);
		logic [SENSORS-1:0][11:0] rd;
		for (int i = 0; i < SENSORS; i++)
			rd[i] = v;
		return rd;
	endfunction

	initial begin
		logic [SENSORS-1:0][11:0] rd;
		int r;
		steer_sb.clear();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_regs(55, 30, 85, 10, 0, 1, 220, 999);

		// Directed part: inverted bounds, ignored operation, equal bounds.
		send_item(OP_FOLLOW, line_scene());
		send_item(OP_NONE, fill(12'hfff));
		send_item(OP_FINISH, fill(0));
		send_item(OP_FOLLOW, fill(0));
		send_item(OP_FOLLOW, fill(4095));
		for (int i = 0; i < SENSORS; i++)
			rd[i] = 800 + 300 * i;
		send_item(OP_CALIBRATE, rd);
		for (int i = 0; i < SENSORS; i++)
			rd[i] = 2000 + 200 * i;
		send_item(OP_CALIBRATE, rd);
		send_item(OP_FINISH, fill(0));
		send_item(OP_FOLLOW, fill(0));
		send_item(OP_FOLLOW, fill(4095));
		send_item(OP_FOLLOW, fill(12'haaa));
		send_item(OP_FOLLOW, fill(12'h555));
		// Line under the leftmost, centre and rightmost sensors.
		foreach (rd[i]) rd[i] = (i == 0) ? 0 : 4095;
		send_item(OP_FOLLOW, rd);
		foreach (rd[i]) rd[i] = (i == 3 || i == 4) ? 0 : 4095;
		send_item(OP_FOLLOW, rd);
		foreach (rd[i]) rd[i] = (i == 7) ? 0 : 4095;
		send_item(OP_FOLLOW, rd);
		drain();

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_regs(100, 0, 100, 127, 1, 0, 0, 65535);
				1: set_regs(0, 100, 0, 0, 0, 1, 8000, 0);
				2: set_regs(50, 20, 70, 64, 1, 1, 1000, 1999);
				3: set_regs($urandom_range(0, 100), $urandom_range(0, 100),
					$urandom_range(0, 100), $urandom_range(0, 127), $urandom_range(0, 1),
					$urandom_range(0, 1), $urandom_range(0, 8000), $urandom_range(0, 65535));
				4: set_regs(30, 40, 90, 100, 0, 0, 300, 12345);
				default: set_regs(55, 30, 85, 10, 0, 1, 220, 999);
			endcase
			gaps_on = (ph != 2);
			for (int n = 0; n < 190; n++) begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					foreach (rd[i]) rd[i] = $urandom_range(1200, 2800);
					send_item(OP_CALIBRATE, rd);
				end else if (r < 8) begin
					send_item(OP_FINISH, line_scene());
				end else if (r < 11) begin
					foreach (rd[i]) rd[i] = $urandom_range(0, 4095);
					send_item(OP_NONE, rd);
				end else if (r < 45) begin
					foreach (rd[i]) rd[i] = $urandom_range(0, 4095);
					send_item(OP_FOLLOW, rd);
				end else begin
					send_item(OP_FOLLOW, line_scene());
				end
			end
			drain();
		end

		gaps_on = 1'b1;
		if (steer_sb.pending.size() != 0)
			steer_sb.report("expected results left over");
		if (steer_sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/lfs_pkg.sv
rtl/lfs_divider.sv
rtl/lfs_lane.sv
rtl/line_follow_steering_top.sv
tb/sv/line_follow_steering_top_tb.sv
